// ===== rtl/core/bidt_pkg.sv =====
// shared types and constants of the blob id tracker
package bidt_pkg;

    // field widths
    localparam int X_W      = 12;
    localparam int P_W      = 16;
    localparam int DIST_W   = 10;
    localparam int OUT_W    = 4;
    localparam int FRAC_W   = 14;

    // arithmetic widths
    localparam int D2_W      = 2 * X_W + 1;
    localparam int SQ_V_W    = 62;
    localparam int SQ_ROOT_W = 27;
    localparam int SQ_REM_W  = 30;
    localparam int DIV_N_W   = 31;
    localparam int DIV_D_W   = P_W + 1;
    localparam int SCORE_W   = 16;
    localparam int MQ_W      = DIST_W + FRAC_W;

    // iteration count of the root and divide units
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = 5'd30;

    localparam logic [DIST_W-1:0]  MAXD_RESET = 10'd100;
    localparam logic [SCORE_W-1:0] LIKE_ONE   = 16'd16384;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_PREP,
        S_STEP_A,
        S_MID,
        S_STEP_B,
        S_SCORE,
        S_HOLD_RD,
        S_COMMIT,
        S_USED_RD,
        S_USED_SET,
        S_ASSIGN,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic load_cur;
        logic clear_match;
        logic prep;
        logic step;
        logic step_sqrt;
        logic mid;
        logic score;
        logic first_c;
        logic commit;
        logic mark_used;
        logic assign_id;
        logic copy_out;
        logic out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic has_c;
        logic used_ptr;
    } dp_sts_t;

endpackage

// ===== rtl/core/bidt_in_if.sv =====
// input channel: one blob per beat
interface bidt_in_if;
    import bidt_pkg::*;

    logic            valid;
    logic            ready;
    logic [X_W-1:0]  center_x;
    logic [X_W-1:0]  center_y;
    logic [P_W-1:0]  perimeter;
    logic            last_blob;
    logic            empty_frame;

    modport source (output valid, center_x, center_y, perimeter, last_blob, empty_frame,
                    input ready);
    modport sink   (input valid, center_x, center_y, perimeter, last_blob, empty_frame,
                    output ready);
endinterface

// ===== rtl/core/bidt_out_if.sv =====
// result channel: one blob id per beat
interface bidt_out_if;
    import bidt_pkg::*;

    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  blob_index;
    logic [OUT_W-1:0]  blob_id;
    logic              last_result;

    modport source (output valid, blob_index, blob_id, last_result, input ready);
    modport sink   (input valid, blob_index, blob_id, last_result, output ready);
endinterface

// ===== rtl/core/bidt_cfg_if.sv =====
// configuration write channel for max_distance
interface bidt_cfg_if;
    import bidt_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/bidt_dpath.sv =====
// datapath: blob stores, root and divide units, score compare, id bookkeeping
module bidt_dpath #(
    parameter int MAX_BLOBS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  bidt_pkg::dp_cmd_t                      cmd,
    output bidt_pkg::dp_sts_t                      sts,
    input  logic [$clog2(MAX_BLOBS)-1:0]           cur_wr_addr,
    input  logic [$clog2(MAX_BLOBS)-1:0]           o_addr,
    input  logic [$clog2(MAX_BLOBS)-1:0]           c_addr,
    input  logic [$clog2(MAX_BLOBS)-1:0]           id_ptr,
    input  logic [bidt_pkg::X_W-1:0]               center_x,
    input  logic [bidt_pkg::X_W-1:0]               center_y,
    input  logic [bidt_pkg::P_W-1:0]               perimeter,
    input  logic                                   cfg_we,
    input  logic [bidt_pkg::DIST_W-1:0]            cfg_data,
    output logic [bidt_pkg::OUT_W-1:0]             blob_index,
    output logic [bidt_pkg::OUT_W-1:0]             blob_id,
    output logic                                   last_result
);
    import bidt_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOBS);

    // blob stores
    logic [X_W-1:0]     cur_x_mem   [MAX_BLOBS];
    logic [X_W-1:0]     cur_y_mem   [MAX_BLOBS];
    logic [P_W-1:0]     cur_p_mem   [MAX_BLOBS];
    logic [X_W-1:0]     prev_x_mem  [MAX_BLOBS];
    logic [X_W-1:0]     prev_y_mem  [MAX_BLOBS];
    logic [P_W-1:0]     prev_p_mem  [MAX_BLOBS];
    logic [IDX_W-1:0]   prev_id_mem [MAX_BLOBS];
    logic [IDX_W-1:0]   ident_mem   [MAX_BLOBS];
    logic [SCORE_W-1:0] hold_mem    [MAX_BLOBS];

    logic [X_W-1:0]     cx_rd, cy_rd, px_rd, py_rd;
    logic [P_W-1:0]     cp_rd, pp_rd;
    logic [IDX_W-1:0]   pid_rd, id_rd;
    logic [SCORE_W-1:0] hold_rd;

    logic [DIST_W-1:0]  maxd_reg;
    logic [MAX_BLOBS-1:0] has_reg, used_reg;

    logic [SQ_V_W-1:0]    sq_v_reg;
    logic [SQ_REM_W-1:0]  sq_rem_reg;
    logic [SQ_ROOT_W-1:0] sq_root_reg;
    logic [DIV_N_W-1:0]   div_num_reg;
    logic [DIV_D_W-1:0]   div_rem_reg;
    logic [DIV_D_W-1:0]   div_den_reg;
    logic                 lim_zero_reg, like_one_reg, like_zero_reg, prox_zero_reg;
    logic [SCORE_W-1:0]   like_reg, best_reg;
    logic [IDX_W-1:0]     bix_reg;
    logic [OUT_W-1:0]     blob_index_reg, blob_id_reg;
    logic                 last_result_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            maxd_reg <= MAXD_RESET;
        end
        else if (cfg_we) begin
            maxd_reg <= cfg_data;
        end
    end

    // current frame store
    always_ff @(posedge clk) begin
        if (cmd.load_cur) begin
            cur_x_mem[cur_wr_addr] <= center_x;
            cur_y_mem[cur_wr_addr] <= center_y;
            cur_p_mem[cur_wr_addr] <= perimeter;
        end
        cx_rd <= cur_x_mem[c_addr];
        cy_rd <= cur_y_mem[c_addr];
        cp_rd <= cur_p_mem[c_addr];
    end

    // previous frame store, refilled while results go out
    always_ff @(posedge clk) begin
        if (cmd.copy_out) begin
            prev_x_mem[c_addr]  <= cx_rd;
            prev_y_mem[c_addr]  <= cy_rd;
            prev_p_mem[c_addr]  <= cp_rd;
            prev_id_mem[c_addr] <= id_rd;
        end
        px_rd  <= prev_x_mem[o_addr];
        py_rd  <= prev_y_mem[o_addr];
        pp_rd  <= prev_p_mem[o_addr];
        pid_rd <= prev_id_mem[o_addr];
    end

    // commit decision for a previous blob's best pick
    logic take_best;
    assign take_best = (best_reg != '0) && (!has_reg[bix_reg] || (best_reg >= hold_rd));

    // id and winning score stores
    always_ff @(posedge clk) begin
        if (cmd.commit && take_best) begin
            ident_mem[bix_reg] <= pid_rd;
            hold_mem[bix_reg]  <= best_reg;
        end
        else if (cmd.assign_id) begin
            ident_mem[c_addr] <= id_ptr;
        end
        id_rd   <= ident_mem[c_addr];
        hold_rd <= hold_mem[bix_reg];
    end

    // matched and used-id flags
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            has_reg  <= '0;
            used_reg <= '0;
        end
        else if (cmd.clear_match) begin
            has_reg  <= '0;
            used_reg <= '0;
        end
        else begin
            if (cmd.commit && take_best) begin
                has_reg[bix_reg] <= 1'b1;
            end
            if (cmd.mark_used && has_reg[c_addr]) begin
                used_reg[id_rd] <= 1'b1;
            end
            if (cmd.assign_id) begin
                has_reg[c_addr] <= 1'b1;
                used_reg[id_ptr] <= 1'b1;
            end
        end
    end

    assign sts.has_c    = has_reg[c_addr];
    assign sts.used_ptr = used_reg[id_ptr];

    // operand setup: squared distance and perimeter terms
    logic [X_W-1:0]     ax, ay;
    logic [2*X_W-1:0]   sq_x, sq_y;
    logic [D2_W-1:0]    d2;
    logic [P_W-1:0]     pdiff;
    logic [DIV_D_W-1:0] lim;
    always_comb begin
        ax    = (px_rd > cx_rd) ? (px_rd - cx_rd) : (cx_rd - px_rd);
        ay    = (py_rd > cy_rd) ? (py_rd - cy_rd) : (cy_rd - py_rd);
        sq_x  = ax * ax;
        sq_y  = ay * ay;
        d2    = {1'b0, sq_x} + {1'b0, sq_y};
        pdiff = (pp_rd > cp_rd) ? (pp_rd - cp_rd) : (cp_rd - pp_rd);
        lim   = {pp_rd, 1'b0};
    end

    // one root digit and one quotient bit per step
    logic [SQ_REM_W-1:0] sq_rem_sh, sq_trial;
    logic                sq_ge;
    logic [DIV_D_W:0]    div_rem_sh, div_sub;
    logic                div_ge;
    always_comb begin
        sq_rem_sh  = {sq_rem_reg[SQ_REM_W-3:0], sq_v_reg[SQ_V_W-1 -: 2]};
        sq_trial   = {1'b0, sq_root_reg, 2'b01};
        sq_ge      = sq_rem_sh >= sq_trial;
        div_rem_sh = {div_rem_reg, div_num_reg[DIV_N_W-1]};
        div_ge     = div_rem_sh >= {1'b0, div_den_reg};
        div_sub    = div_rem_sh - {1'b0, div_den_reg};
    end

    // proximity setup from the finished root
    logic [DIST_W-1:0] m_eff;
    logic [MQ_W-1:0]   mq, mq_left;
    always_comb begin
        m_eff   = (maxd_reg == '0) ? DIST_W'(1) : maxd_reg;
        mq      = {m_eff, {FRAC_W{1'b0}}};
        mq_left = mq - sq_root_reg[MQ_W-1:0];
    end

    // pair score
    logic [SCORE_W-1:0] prox, score;
    always_comb begin
        prox  = prox_zero_reg ? '0 : div_num_reg[SCORE_W-1:0];
        score = prox + like_reg;
    end

    // root, divide and best-pick registers
    always_ff @(posedge clk) begin
        if (cmd.prep) begin
            sq_v_reg      <= {{(SQ_V_W-D2_W-2*FRAC_W){1'b0}}, d2, {(2*FRAC_W){1'b0}}};
            sq_rem_reg    <= '0;
            sq_root_reg   <= '0;
            div_num_reg   <= {(lim - {1'b0, pdiff}), {FRAC_W{1'b0}}};
            div_den_reg   <= lim;
            div_rem_reg   <= '0;
            lim_zero_reg  <= (pp_rd == '0);
            like_one_reg  <= (cp_rd == '0);
            like_zero_reg <= ({1'b0, pdiff} > lim);
        end
        else if (cmd.mid) begin
            if (lim_zero_reg) begin
                like_reg <= like_one_reg ? LIKE_ONE : '0;
            end
            else begin
                like_reg <= like_zero_reg ? '0 : div_num_reg[SCORE_W-1:0];
            end
            prox_zero_reg <= sq_root_reg > {{(SQ_ROOT_W-MQ_W){1'b0}}, mq};
            div_num_reg   <= {{(DIV_N_W-MQ_W-1){1'b0}}, mq_left, 1'b0};
            div_den_reg   <= {{(DIV_D_W-DIST_W){1'b0}}, m_eff};
            div_rem_reg   <= '0;
        end
        else if (cmd.step) begin
            div_num_reg <= {div_num_reg[DIV_N_W-2:0], div_ge};
            div_rem_reg <= div_ge ? div_sub[DIV_D_W-1:0] : div_rem_sh[DIV_D_W-1:0];
            if (cmd.step_sqrt) begin
                sq_v_reg    <= {sq_v_reg[SQ_V_W-3:0], 2'b00};
                sq_rem_reg  <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
                sq_root_reg <= {sq_root_reg[SQ_ROOT_W-2:0], sq_ge};
            end
        end
        if (cmd.score && (cmd.first_c || (score > best_reg))) begin
            best_reg <= score;
            bix_reg  <= c_addr;
        end
    end

    // result register
    logic [IDX_W+OUT_W-1:0] idx_ext, id_ext;
    assign idx_ext = {{OUT_W{1'b0}}, c_addr};
    assign id_ext  = {{OUT_W{1'b0}}, id_rd};

    always_ff @(posedge clk) begin
        if (cmd.copy_out) begin
            blob_index_reg  <= idx_ext[OUT_W-1:0];
            blob_id_reg     <= id_ext[OUT_W-1:0];
            last_result_reg <= cmd.out_last;
        end
    end

    assign blob_index  = blob_index_reg;
    assign blob_id     = blob_id_reg;
    assign last_result = last_result_reg;

endmodule

// ===== rtl/core/bidt_ctrl.sv =====
// controller: frame loading, pair scoring sequence, id assignment and output
module bidt_ctrl #(
    parameter int MAX_BLOBS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_last,
    input  logic                           in_empty,
    output logic                           in_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bidt_pkg::dp_cmd_t              cmd,
    input  bidt_pkg::dp_sts_t              sts,
    output logic [$clog2(MAX_BLOBS)-1:0]   cur_wr_addr,
    output logic [$clog2(MAX_BLOBS)-1:0]   o_addr,
    output logic [$clog2(MAX_BLOBS)-1:0]   c_addr,
    output logic [$clog2(MAX_BLOBS)-1:0]   id_ptr
);
    import bidt_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOBS);
    localparam int CNT_W = $clog2(MAX_BLOBS + 1);

    state_t state_reg, state_next;
    logic [CNT_W-1:0]  cur_cnt_reg, cur_cnt_next;
    logic [CNT_W-1:0]  prev_cnt_reg, prev_cnt_next;
    logic [IDX_W-1:0]  o_reg, o_next;
    logic [IDX_W-1:0]  c_reg, c_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic accept, room, c_last, o_last, step_last, take_c;
    always_comb begin
        accept    = (state_reg == S_IDLE) && in_valid;
        room      = cur_cnt_reg < CNT_W'(MAX_BLOBS);
        c_last    = (CNT_W'(c_reg) + CNT_W'(1)) == cur_cnt_reg;
        o_last    = (CNT_W'(o_reg) + CNT_W'(1)) == prev_cnt_reg;
        step_last = step_reg == STEP_LAST;
        take_c    = sts.has_c || !sts.used_ptr;
    end

    // state register and counters
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= S_IDLE;
            cur_cnt_reg  <= '0;
            prev_cnt_reg <= '0;
            o_reg        <= '0;
            c_reg        <= '0;
            ptr_reg      <= '0;
            step_reg     <= '0;
        end
        else begin
            state_reg    <= state_next;
            cur_cnt_reg  <= cur_cnt_next;
            prev_cnt_reg <= prev_cnt_next;
            o_reg        <= o_next;
            c_reg        <= c_next;
            ptr_reg      <= ptr_next;
            step_reg     <= step_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && !in_empty && in_last) begin
                    state_next = (prev_cnt_reg == '0) ? S_USED_RD : S_RD;
                end
            end
            S_RD:       state_next = S_PREP;
            S_PREP:     state_next = S_STEP_A;
            S_STEP_A:   state_next = step_last ? S_MID : S_STEP_A;
            S_MID:      state_next = S_STEP_B;
            S_STEP_B:   state_next = step_last ? S_SCORE : S_STEP_B;
            S_SCORE:    state_next = c_last ? S_HOLD_RD : S_RD;
            S_HOLD_RD:  state_next = S_COMMIT;
            S_COMMIT:   state_next = o_last ? S_USED_RD : S_RD;
            S_USED_RD:  state_next = S_USED_SET;
            S_USED_SET: state_next = c_last ? S_ASSIGN : S_USED_RD;
            S_ASSIGN: begin
                if (take_c && c_last) begin
                    state_next = S_OUT_RD;
                end
            end
            S_OUT_RD:   state_next = S_OUT_LD;
            S_OUT_LD:   state_next = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (out_ready) begin
                    state_next = c_last ? S_IDLE : S_OUT_RD;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // counter updates
    always_comb begin
        cur_cnt_next  = cur_cnt_reg;
        prev_cnt_next = prev_cnt_reg;
        o_next        = o_reg;
        c_next        = c_reg;
        ptr_next      = ptr_reg;
        step_next     = step_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_empty) begin
                        cur_cnt_next  = '0;
                        prev_cnt_next = '0;
                    end
                    else begin
                        if (room) begin
                            cur_cnt_next = cur_cnt_reg + CNT_W'(1);
                        end
                        if (in_last) begin
                            o_next   = '0;
                            c_next   = '0;
                            ptr_next = '0;
                        end
                    end
                end
            end
            S_STEP_A, S_STEP_B: begin
                step_next = step_last ? '0 : step_reg + STEP_W'(1);
            end
            S_SCORE: begin
                c_next = c_last ? '0 : c_reg + IDX_W'(1);
            end
            S_COMMIT: begin
                o_next = o_reg + IDX_W'(1);
            end
            S_USED_SET: begin
                c_next = c_last ? '0 : c_reg + IDX_W'(1);
            end
            S_ASSIGN: begin
                if (take_c) begin
                    c_next = c_last ? '0 : c_reg + IDX_W'(1);
                end
                else begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            S_OUT_WAIT: begin
                if (out_ready) begin
                    if (c_last) begin
                        prev_cnt_next = cur_cnt_reg;
                        cur_cnt_next  = '0;
                    end
                    else begin
                        c_next = c_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // datapath commands and handshake outputs
    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready        = 1'b1;
                cmd.load_cur    = in_valid && !in_empty && room;
                cmd.clear_match = in_valid && !in_empty && in_last;
            end
            S_PREP:   cmd.prep = 1'b1;
            S_STEP_A: begin
                cmd.step      = 1'b1;
                cmd.step_sqrt = 1'b1;
            end
            S_MID:    cmd.mid = 1'b1;
            S_STEP_B: cmd.step = 1'b1;
            S_SCORE: begin
                cmd.score   = 1'b1;
                cmd.first_c = (c_reg == '0);
            end
            S_COMMIT:   cmd.commit = 1'b1;
            S_USED_SET: cmd.mark_used = 1'b1;
            // unmatched blob takes the pointer id once it is free
            S_ASSIGN:   cmd.assign_id = !sts.has_c && !sts.used_ptr;
            S_OUT_LD: begin
                cmd.copy_out = 1'b1;
                cmd.out_last = c_last;
            end
            S_OUT_WAIT: out_valid = 1'b1;
            default: begin
            end
        endcase
    end

    assign cur_wr_addr = cur_cnt_reg[IDX_W-1:0];
    assign o_addr      = o_reg;
    assign c_addr      = c_reg;
    assign id_ptr      = ptr_reg;

    // input and output never both open
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    // frame fill never passes the store depth
    a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_cnt_reg <= CNT_W'(MAX_BLOBS))
        else $error("current frame count overflow");

    // scoring only visits stored previous blobs
    a_o_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (CNT_W'(o_reg) < prev_cnt_reg))
        else $error("previous blob index out of range");

    // every output beat belongs to a stored blob
    a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CNT_W'(c_reg) < cur_cnt_reg))
        else $error("output index out of range");

    // a taken last beat ends the frame sweep
    a_out_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && c_last) |=> (state_reg == S_IDLE) && (cur_cnt_reg == '0))
        else $error("frame not closed after final result");

endmodule

// ===== rtl/core/blob_id_tracker_core.sv =====
// top level of the blob id tracker
//
//  channel   dir   payload                                               beat when
//  blob_in   in    center_x, center_y, perimeter, last_blob, empty_frame  valid & ready
//  blob_out  out   blob_index, blob_id, last_result                      valid & ready
//  cfg       in    data (max_distance)                                   valid & ready
//
//  a blob beat is taken while idle; the final blob of a frame starts matching
//  (or id assignment with no previous blobs); each (previous, new) pair is scored:
//  the shared root and divide units run 31 steps for each of the two score terms
//  each previous blob then commits its best pick, then ids are assigned and results sent
//  input stays closed from the final blob until the last result beat is taken
//  reset clears counts, flags and max_distance (100); no clearing pass is needed
module blob_id_tracker_core #(
    parameter int MAX_BLOBS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    bidt_in_if.sink       blob_in,
    bidt_out_if.source    blob_out,
    bidt_cfg_if.sink      cfg
);
    import bidt_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOBS);

    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic [IDX_W-1:0] cur_wr_addr, o_addr, c_addr, id_ptr;

    // configuration is always taken
    assign cfg.ready = 1'b1;

    // sequencer
    bidt_ctrl #(
        .MAX_BLOBS (MAX_BLOBS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (blob_in.valid),
        .in_last     (blob_in.last_blob),
        .in_empty    (blob_in.empty_frame),
        .in_ready    (blob_in.ready),
        .out_valid   (blob_out.valid),
        .out_ready   (blob_out.ready),
        .cmd         (cmd),
        .sts         (sts),
        .cur_wr_addr (cur_wr_addr),
        .o_addr      (o_addr),
        .c_addr      (c_addr),
        .id_ptr      (id_ptr)
    );

    // stores and arithmetic
    bidt_dpath #(
        .MAX_BLOBS (MAX_BLOBS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cur_wr_addr (cur_wr_addr),
        .o_addr      (o_addr),
        .c_addr      (c_addr),
        .id_ptr      (id_ptr),
        .center_x    (blob_in.center_x),
        .center_y    (blob_in.center_y),
        .perimeter   (blob_in.perimeter),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.data),
        .blob_index  (blob_out.blob_index),
        .blob_id     (blob_out.blob_id),
        .last_result (blob_out.last_result)
    );

endmodule

// ===== bench/tb_scoreboard.sv =====
// scoreboard for the blob id tracker: id prediction and result checking
`timescale 1ns / 1ps

class blob_id_scoreboard;

    typedef struct packed {
        logic [bidt_pkg::OUT_W-1:0] blob_index;
        logic [bidt_pkg::OUT_W-1:0] blob_id;
        logic                       last_result;
    } id_beat_t;

    logic [bidt_pkg::DIST_W-1:0] max_dist;
    logic [bidt_pkg::X_W-1:0]    old_x[16], old_y[16], new_x[16], new_y[16];
    logic [bidt_pkg::P_W-1:0]    old_p[16], new_p[16];
    logic [3:0]                  old_id[16];
    int                          old_n, new_n;
    id_beat_t                    pending_ids[$];
    int                          errors;

    function new();
        max_dist = bidt_pkg::MAXD_RESET;
        old_n    = 0;
        new_n    = 0;
        errors   = 0;
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Q2.14 match score of old blob o against new blob c
    function automatic longint unsigned match_score(int o, int c);
        longint unsigned m, d2, dq, mq, prox, p, q, diff, lim, like;
        longint dx, dy;
        m    = (max_dist == 0) ? 1 : max_dist;
        dx   = longint'(old_x[o]) - longint'(new_x[c]);
        dy   = longint'(old_y[o]) - longint'(new_y[c]);
        d2   = dx * dx + dy * dy;
        dq   = int_root(d2 << 28);
        mq   = m << 14;
        prox = (dq > mq) ? 0 : ((mq - dq) * 2) / m;
        p    = old_p[o];
        q    = new_p[c];
        diff = (p > q) ? p - q : q - p;
        lim  = 2 * p;
        if (lim == 0)
            like = (diff == 0) ? 16384 : 0;
        else
            like = (diff > lim) ? 0 : ((lim - diff) << 14) / lim;
        return prox + like;
    endfunction

    // note an accepted blob beat and predict the frame's ids on its final blob
    function void note_blob(logic [bidt_pkg::X_W-1:0] x, logic [bidt_pkg::X_W-1:0] y,
                            logic [bidt_pkg::P_W-1:0] p, logic last, logic empty);
        longint unsigned best, s, held[16];
        logic [3:0] ids[16];
        bit         taken[16], clash;
        int         bix, id;
        id_beat_t   r;
        if (empty)
        begin
            old_n = 0;
            new_n = 0;
            return;
        end
        if (new_n < 16)
        begin
            new_x[new_n] = x;
            new_y[new_n] = y;
            new_p[new_n] = p;
            new_n++;
        end
        if (!last || new_n == 0)
            return;
        for (int c = 0; c < 16; c++)
        begin
            taken[c] = 0;
            held[c]  = 0;
            ids[c]   = 0;
        end
        // each old blob hands its id to its best new blob if nonzero and not below the held score
        for (int o = 0; o < old_n; o++)
        begin
            best = match_score(o, 0);
            bix  = 0;
            for (int c = 1; c < new_n; c++)
            begin
                s = match_score(o, c);
                if (s > best)
                begin
                    best = s;
                    bix  = c;
                end
            end
            if (best == 0)
                continue;
            if (!taken[bix] || best >= held[bix])
            begin
                taken[bix] = 1;
                held[bix]  = best;
                ids[bix]   = old_id[o];
            end
        end
        // unmatched blobs take the smallest free id
        for (int c = 0; c < new_n; c++)
        begin
            if (taken[c])
                continue;
            id    = 0;
            clash = 1;
            while (clash)
            begin
                clash = 0;
                for (int k = 0; k < new_n; k++)
                    if (taken[k] && ids[k] == id)
                    begin
                        clash = 1;
                        id++;
                        break;
                    end
            end
            ids[c]   = 4'(id);
            taken[c] = 1;
        end
        for (int c = 0; c < new_n; c++)
        begin
            r.blob_index  = bidt_pkg::OUT_W'(c);
            r.blob_id     = ids[c];
            r.last_result = (c + 1 == new_n);
            pending_ids   = {pending_ids, r};
            old_x[c]  = new_x[c];
            old_y[c]  = new_y[c];
            old_p[c]  = new_p[c];
            old_id[c] = ids[c];
        end
        old_n = new_n;
        new_n = 0;
    endfunction

    // compare a result beat with the oldest predicted id
    function void check_id(logic [bidt_pkg::OUT_W-1:0] idx, logic [bidt_pkg::OUT_W-1:0] id,
                           logic last);
        id_beat_t e;
        if (pending_ids.size() == 0)
        begin
            $error("unexpected result beat index %0d id %0d", idx, id);
            errors++;
            return;
        end
        e = pending_ids.pop_front();
        if (idx !== e.blob_index)
        begin
            $error("blob_index expected %0d actual %0d", e.blob_index, idx);
            errors++;
        end
        if (id !== e.blob_id)
        begin
            $error("blob_id expected %0d actual %0d", e.blob_id, id);
            errors++;
        end
        if (last !== e.last_result)
        begin
            $error("last_result expected %0d actual %0d", e.last_result, last);
            errors++;
        end
    endfunction
endclass

// ===== bench/tb.sv =====
// testbench top for the blob id tracker core
`timescale 1ns / 1ps

module tb;
    import bidt_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    bit   calm = 0;

    bidt_in_if  blob_in ();
    bidt_out_if blob_out ();
    bidt_cfg_if cfg ();

    blob_id_scoreboard sb = new();

    blob_id_tracker_core #(.MAX_BLOBS(16)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .blob_in (blob_in),
        .blob_out(blob_out),
        .cfg     (cfg)
    );

    // clock
    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // run limit
    initial
    begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    // result sink with random stalls
    initial
    begin
        blob_out.ready = 0;
        forever
        begin
            @(negedge clk);
            blob_out.ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    // check every result beat
    always @(posedge clk)
        if (rst_n && blob_out.valid && blob_out.ready)
            sb.check_id(blob_out.blob_index, blob_out.blob_id, blob_out.last_result);

    task automatic write_max_dist(logic [DIST_W-1:0] v);
        cfg.valid <= 1;
        cfg.data  <= v;
        do @(posedge clk); while (!cfg.ready);
        sb.max_dist = v;
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    // valid stays up after the beat until the next call or a drain
    task automatic send_blob(logic [X_W-1:0] x, logic [X_W-1:0] y, logic [P_W-1:0] p,
                             logic last, logic empty);
        while (!calm && $urandom_range(99) < 21)
        begin
            blob_in.valid <= 0;
            @(negedge clk);
        end
        blob_in.valid       <= 1;
        blob_in.center_x    <= x;
        blob_in.center_y    <= y;
        blob_in.perimeter   <= p;
        blob_in.last_blob   <= last;
        blob_in.empty_frame <= empty;
        do @(posedge clk); while (!blob_in.ready);
        sb.note_blob(x, y, p, last, empty);
        @(negedge clk);
    endtask

    task automatic drain();
        blob_in.valid <= 0;
        while (sb.pending_ids.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // frame of n blobs, some near the previous ones, random jitter
    task automatic send_frame(int n, int spread);
        int base_x, base_y;
        base_x = $urandom_range(4095);
        base_y = $urandom_range(4095);
        for (int i = 0; i < n; i++)
        begin
            if (i < sb.old_n && $urandom_range(3) != 0)
                send_blob(X_W'(sb.old_x[i] + $urandom_range(spread) - spread / 2),
                          X_W'(sb.old_y[i] + $urandom_range(spread) - spread / 2),
                          P_W'(sb.old_p[i] + $urandom_range(spread) - spread / 2),
                          i == n - 1, 1'b0);
            else
                send_blob(X_W'(base_x + $urandom_range(2 * spread)),
                          X_W'(base_y + $urandom_range(2 * spread)),
                          P_W'($urandom_range(65535) >> $urandom_range(15)),
                          i == n - 1, 1'b0);
        end
    endtask

    initial
    begin
        int sent;
        logic [DIST_W-1:0] dist_set[4];
        dist_set            = '{10'd1, 10'd1023, 10'd0, 10'd100};
        blob_in.valid       = 0;
        blob_in.center_x    = 0;
        blob_in.center_y    = 0;
        blob_in.perimeter   = 0;
        blob_in.last_blob   = 0;
        blob_in.empty_frame = 0;
        cfg.valid           = 0;
        cfg.data            = 0;
        repeat (7) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: extremes, zero perimeters, ties, an empty frame
        send_blob(12'd0, 12'd0, 16'd0, 1'b0, 1'b0);
        send_blob(12'hFFF, 12'hFFF, 16'hFFFF, 1'b1, 1'b0);
        send_blob(12'd0, 12'd0, 16'd0, 1'b0, 1'b0);
        send_blob(12'd0, 12'd0, 16'd0, 1'b0, 1'b0);
        send_blob(12'hFFF, 12'hFFF, 16'hFFFF, 1'b1, 1'b0);
        send_blob(12'd5, 12'd5, 16'd10, 1'b0, 1'b0);
        send_blob(12'd7, 12'd7, 16'd0, 1'b1, 1'b1);
        send_blob(12'd100, 12'd100, 16'd40, 1'b0, 1'b0);
        send_blob(12'd100, 12'd100, 16'd40, 1'b1, 1'b0);
        send_blob(12'd100, 12'd100, 16'd40, 1'b1, 1'b0);
        send_blob(12'hAAA, 12'h555, 16'h5555, 1'b1, 1'b0);
        // overflow: 18 blobs, last two dropped, the last still starts matching
        for (int i = 0; i < 18; i++)
            send_blob(X_W'(i * 200), X_W'(4095 - i * 200), P_W'(i * 3000), i == 17, 1'b0);
        sent = 29;
        drain();

        // random frames under several distance settings
        for (int phase = 0; phase < 4; phase++)
        begin
            write_max_dist(dist_set[phase]);
            for (int f = 0; f < 20; f++)
            begin
                int n;
                calm = (phase == 1 && f < 8);
                n = ($urandom_range(9) == 0) ? $urandom_range(16, 17) : $urandom_range(1, 5);
                if ($urandom_range(15) == 0)
                begin
                    send_blob(X_W'($urandom), X_W'($urandom), P_W'($urandom), 1'($urandom),
                              1'b1);
                    sent++;
                end
                send_frame(n, $urandom_range(1) ? 8 : 300);
                sent += n;
                if (sent > 400)
                    break;
            end
            calm = 0;
            drain();
        end

        if (sb.errors == 0 && sb.pending_ids.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
